// ----- rtl/crcfr_pkg.sv -----
// Shared constants, types and CRC function of the CRC-checked frame receiver.
package crcfr_pkg;

  localparam int unsigned BufBytes  = 32;
  localparam int unsigned HeadBytes = 2;
  localparam int unsigned TailBytes = 3;
  localparam int unsigned BufAw     = $clog2(BufBytes);
  localparam int unsigned CntW      = BufAw + 1;
  localparam logic [7:0]  MaxLen    = 8'(BufBytes - HeadBytes - TailBytes);

  localparam logic [1:0] STATUS_GOOD  = 2'd0;
  localparam logic [1:0] STATUS_CRC   = 2'd1;
  localparam logic [1:0] STATUS_LEN   = 2'd2;
  localparam logic [1:0] STATUS_FRAME = 2'd3;

  localparam logic [1:0] REG_START_CODE  = 2'd0;
  localparam logic [1:0] REG_END_CODE    = 2'd1;
  localparam logic [1:0] REG_CRC_INITIAL = 2'd2;

  localparam logic [7:0]  START_CODE_RST  = 8'h7E;
  localparam logic [7:0]  END_CODE_RST    = 8'h7F;
  localparam logic [15:0] CRC_INITIAL_RST = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'h1021;

  typedef struct packed {
    logic [7:0]  start_code;
    logic [7:0]  end_code;
    logic [15:0] crc_initial;
  } cfg_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data_byte;
    logic       data_valid;
    logic [4:0] frame_length;
    logic       last_of_run;
  } res_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/crcfr_if.sv -----
// Valid/ready channel interfaces for received bytes and frame results.
interface crcfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface crcfr_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] data_byte;
  logic       data_valid;
  logic [4:0] frame_length;
  logic       last_of_run;
  modport source (output valid, output status, output data_byte, output data_valid,
                  output frame_length, output last_of_run, input ready);
  modport sink (input valid, input status, input data_byte, input data_valid,
                input frame_length, input last_of_run, output ready);
endinterface

// ----- rtl/crc_checked_frame_receiver_core.sv -----
// Top level of the CRC-checked frame receiver: register port, input queue and frame engine.
//
//   channel  | dir | transaction
//   rx_i     | in  | one received byte (valid/ready)
//   res_o    | out | one frame result (valid/ready)
//   APB      | in  | register write/read, pready always high
//
// An input byte is fetched, then parsed. At a frame end the frame engine sweeps
// its frame RAM one byte at a time: CRC over payload plus 2 CRC bytes, then the
// payload output, or after a framing error the start code search and replay copy.
// A two-entry input queue takes up to two bytes while the engine sweeps or a result stalls.
// Reset is asynchronous and clears all control state; no clearing pass is needed.
module crc_checked_frame_receiver_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  crcfr_rx_if.sink           rx_i,
  crcfr_res_if.source        res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import crcfr_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       fifo_valid, fifo_pop;
  logic [7:0] fifo_data;
  res_t       res;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_START_CODE:  cfg_d.start_code  = pwdata[7:0];
        REG_END_CODE:    cfg_d.end_code    = pwdata[7:0];
        REG_CRC_INITIAL: cfg_d.crc_initial = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_START_CODE:  prdata = {24'd0, cfg_q.start_code};
      REG_END_CODE:    prdata = {24'd0, cfg_q.end_code};
      REG_CRC_INITIAL: prdata = {16'd0, cfg_q.crc_initial};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{START_CODE_RST, END_CODE_RST, CRC_INITIAL_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  crcfr_in_fifo u_in_fifo (
    .clk_i, .rst_ni,
    .push_valid_i(rx_i.valid), .push_ready_o(rx_i.ready), .push_data_i(rx_i.rx_byte),
    .pop_valid_o(fifo_valid), .pop_ready_i(fifo_pop), .pop_data_o(fifo_data)
  );

  crcfr_engine u_engine (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .byte_valid_i(fifo_valid), .byte_i(fifo_data), .byte_pop_o(fifo_pop),
    .res_valid_o(res_o.valid), .res_ready_i(res_o.ready), .res_o(res)
  );

  assign res_o.status       = res.status;
  assign res_o.data_byte    = res.data_byte;
  assign res_o.data_valid   = res.data_valid;
  assign res_o.frame_length = res.frame_length;
  assign res_o.last_of_run  = res.last_of_run;
endmodule

// ----- rtl/crcfr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module crcfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- rtl/crcfr_in_fifo.sv -----
// Two-entry byte queue between the receive port and the frame engine.
module crcfr_in_fifo (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  logic [7:0] push_data_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output logic [7:0] pop_data_o
);
  logic [7:0] buf_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = buf_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= push_data_i;
    end
  end
endmodule

// ----- rtl/crcfr_engine.sv -----
// Frame parser: stores frames, checks CRC, emits results and replays after framing errors.
module crcfr_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  crcfr_pkg::cfg_t   cfg_i,
  input  logic              byte_valid_i,
  input  logic [7:0]        byte_i,
  output logic              byte_pop_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output crcfr_pkg::res_t   res_o
);
  import crcfr_pkg::*;

  localparam logic [3:0] S_FETCH  = 4'd0;
  localparam logic [3:0] S_QWAIT  = 4'd1;
  localparam logic [3:0] S_PARSE  = 4'd2;
  localparam logic [3:0] S_CRC_W  = 4'd3;
  localparam logic [3:0] S_CRC_U  = 4'd4;
  localparam logic [3:0] S_CHECK  = 4'd5;
  localparam logic [3:0] S_EMIT_W = 4'd6;
  localparam logic [3:0] S_EMIT_U = 4'd7;
  localparam logic [3:0] S_FERR   = 4'd8;
  localparam logic [3:0] S_SRCH_W = 4'd9;
  localparam logic [3:0] S_SRCH_U = 4'd10;
  localparam logic [3:0] S_COPY_W = 4'd11;
  localparam logic [3:0] S_COPY_U = 4'd12;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  logic [3:0]      state_q, state_d;
  logic [1:0]      phase_q, phase_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [4:0]      exp_q, exp_d;
  logic [CntW-1:0] n_q, n_d;
  logic [7:0]      byte_q, byte_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic [15:0]     crc_q, crc_d;
  logic [15:0]     got_q, got_d;
  logic [BufAw-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [CntW-1:0] pend_q, pend_d;
  res_t            res_q, res_d;
  logic            res_valid_q, res_valid_d;

  logic             fs_we, q_we;
  logic [BufAw-1:0] fs_waddr;
  logic [7:0]       fs_wdata, fs_rdata, q_rdata;
  logic             slot_free;
  logic [CntW-1:0]  total, fill_inc, rep_len, exp_ext;

  crcfr_ram #(.Width(8), .Depth(BufBytes)) u_frame_ram (
    .clk_i, .we_i(fs_we), .waddr_i(fs_waddr), .wdata_i(fs_wdata),
    .raddr_i(ptr_q[BufAw-1:0]), .rdata_o(fs_rdata)
  );

  crcfr_ram #(.Width(8), .Depth(BufBytes)) u_replay_ram (
    .clk_i, .we_i(q_we), .waddr_i(wp_q), .wdata_i(fs_rdata),
    .raddr_i(rp_q), .rdata_o(q_rdata)
  );

  assign slot_free   = !res_valid_q || res_ready_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign exp_ext     = CntW'(exp_q);
  assign total       = exp_ext + CntW'(HeadBytes + TailBytes);
  assign fill_inc    = fill_q + 1'b1;
  assign rep_len     = n_q - ptr_q;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    fill_d      = fill_q;
    exp_d       = exp_q;
    n_d         = n_q;
    byte_d      = byte_q;
    ptr_d       = ptr_q;
    crc_d       = crc_q;
    got_d       = got_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    pend_d      = pend_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_ready_i;
    fs_we       = 1'b0;
    fs_waddr    = fill_q[BufAw-1:0];
    fs_wdata    = byte_q;
    q_we        = 1'b0;
    byte_pop_o  = 1'b0;

    unique case (state_q)
      S_FETCH: begin
        if (pend_q != '0) begin
          rp_d    = rp_q + 1'b1;
          pend_d  = pend_q - 1'b1;
          state_d = S_QWAIT;
        end else if (byte_valid_i) begin
          byte_pop_o = 1'b1;
          byte_d     = byte_i;
          state_d    = S_PARSE;
        end
      end
      S_QWAIT: begin
        byte_d  = q_rdata;
        state_d = S_PARSE;
      end
      S_PARSE: begin
        unique case (phase_q)
          PH_IDLE: begin
            if (byte_q == cfg_i.start_code) begin
              fs_we    = 1'b1;
              fs_waddr = '0;
              fill_d   = CntW'(1);
              phase_d  = PH_LEN;
            end
            state_d = S_FETCH;
          end
          PH_LEN: begin
            if (byte_q > MaxLen) begin
              if (slot_free) begin
                res_d       = '{STATUS_LEN, 8'h00, 1'b0, 5'd0, 1'b1};
                res_valid_d = 1'b1;
                phase_d     = PH_IDLE;
                fill_d      = '0;
                state_d     = S_FETCH;
              end
            end else begin
              exp_d   = byte_q[4:0];
              fs_we   = 1'b1;
              fill_d  = fill_inc;
              phase_d = PH_BODY;
              state_d = S_FETCH;
            end
          end
          default: begin
            fs_we  = 1'b1;
            fill_d = fill_inc;
            if (fill_inc < total) begin
              state_d = S_FETCH;
            end else begin
              n_d     = fill_inc;
              phase_d = PH_IDLE;
              fill_d  = '0;
              if (byte_q == cfg_i.end_code) begin
                crc_d   = cfg_i.crc_initial;
                ptr_d   = CntW'(HeadBytes);
                state_d = S_CRC_W;
              end else begin
                state_d = S_FERR;
              end
            end
          end
        endcase
      end
      S_CRC_W: state_d = S_CRC_U;
      S_CRC_U: begin
        if (ptr_q < exp_ext + CntW'(HeadBytes)) begin
          crc_d   = crc_byte(crc_q, fs_rdata);
          ptr_d   = ptr_q + 1'b1;
          state_d = S_CRC_W;
        end else if (ptr_q == exp_ext + CntW'(HeadBytes)) begin
          got_d[7:0] = fs_rdata;
          ptr_d      = ptr_q + 1'b1;
          state_d    = S_CRC_W;
        end else begin
          got_d[15:8] = fs_rdata;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (crc_q != got_q) begin
          if (slot_free) begin
            res_d       = '{STATUS_CRC, 8'h00, 1'b0, exp_q, 1'b1};
            res_valid_d = 1'b1;
            state_d     = S_FETCH;
          end
        end else if (exp_q == '0) begin
          if (slot_free) begin
            res_d       = '{STATUS_GOOD, 8'h00, 1'b0, 5'd0, 1'b1};
            res_valid_d = 1'b1;
            state_d     = S_FETCH;
          end
        end else begin
          ptr_d   = CntW'(HeadBytes);
          state_d = S_EMIT_W;
        end
      end
      S_EMIT_W: state_d = S_EMIT_U;
      S_EMIT_U: begin
        if (slot_free) begin
          res_d       = '{STATUS_GOOD, fs_rdata, 1'b1, exp_q,
                          ptr_q == exp_ext + CntW'(HeadBytes - 1)};
          res_valid_d = 1'b1;
          if (ptr_q == exp_ext + CntW'(HeadBytes - 1)) begin
            state_d = S_FETCH;
          end else begin
            ptr_d   = ptr_q + 1'b1;
            state_d = S_EMIT_W;
          end
        end
      end
      S_FERR: begin
        if (slot_free) begin
          res_d       = '{STATUS_FRAME, 8'h00, 1'b0, exp_q, 1'b1};
          res_valid_d = 1'b1;
          ptr_d       = CntW'(1);
          state_d     = S_SRCH_W;
        end
      end
      S_SRCH_W: state_d = S_SRCH_U;
      S_SRCH_U: begin
        if (fs_rdata == cfg_i.start_code) begin
          wp_d    = rp_q - rep_len[BufAw-1:0];
          rp_d    = rp_q - rep_len[BufAw-1:0];
          pend_d  = pend_q + rep_len;
          state_d = S_COPY_U;
        end else if (ptr_q + CntW'(2) >= n_q) begin
          state_d = S_FETCH;
        end else begin
          ptr_d   = ptr_q + 1'b1;
          state_d = S_SRCH_W;
        end
      end
      S_COPY_W: state_d = S_COPY_U;
      S_COPY_U: begin
        q_we = 1'b1;
        if (ptr_q + 1'b1 == n_q) begin
          state_d = S_FETCH;
        end else begin
          ptr_d   = ptr_q + 1'b1;
          wp_d    = wp_q + 1'b1;
          state_d = S_COPY_W;
        end
      end
      default: state_d = S_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FETCH;
      phase_q     <= PH_IDLE;
      fill_q      <= '0;
      exp_q       <= '0;
      rp_q        <= '0;
      pend_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      fill_q      <= fill_d;
      exp_q       <= exp_d;
      rp_q        <= rp_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    byte_q <= byte_d;
    ptr_q  <= ptr_d;
    crc_q  <= crc_d;
    got_q  <= got_d;
    wp_q   <= wp_d;
    res_q  <= res_d;
  end
endmodule

// ----- rtl/crcfr_checker.sv -----
// Port-level assertions for the frame receiver, bound to the top level.
module crcfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] status,
  input logic [7:0] data_byte,
  input logic       data_valid,
  input logic       last_of_run
);
  import crcfr_pkg::*;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && status != STATUS_GOOD |-> !data_valid && last_of_run)
    else $error("error result not a single closing result");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !data_valid |-> data_byte == 8'h00)
    else $error("data byte set without payload");

  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready && !last_of_run |=> !(res_valid && status != STATUS_GOOD))
    else $error("error result inside a payload run");
endmodule

bind crc_checked_frame_receiver_core crcfr_checker u_crcfr_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .res_valid(res_o.valid),
  .res_ready(res_o.ready),
  .status(res_o.status),
  .data_byte(res_o.data_byte),
  .data_valid(res_o.data_valid),
  .last_of_run(res_o.last_of_run)
);

// ----- sim/crcfr_tb_if.sv -----
`timescale 1ns / 100ps
// Channel interfaces used by the frame receiver testbench (compiled with the RTL interfaces).
interface crcfr_tb_apb_if;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
endinterface

// ----- sim/crc_checked_frame_receiver_core_tb.sv -----
`timescale 1ns / 100ps
// Testbench of the CRC-checked frame receiver: directed and random byte streams checked
// against a behavioral frame parser with replay.
module crc_checked_frame_receiver_core_tb;
  import crcfr_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_LENGTH, PH_BODY} phase_e;

  typedef struct {
    logic [7:0] rx;
    logic       has_want;
    res_t       want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [31:0] prdata;
  logic pready;

  crcfr_rx_if rx_ch ();
  crcfr_res_if res_ch ();
  crcfr_tb_apb_if apb ();

  crc_checked_frame_receiver_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .rx_i(rx_ch.sink), .res_o(res_ch.source),
    .psel(apb.psel), .penable(apb.penable), .pwrite(apb.pwrite), .paddr(apb.paddr),
    .pwdata(apb.pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  logic [7:0]  cfg_start = START_CODE_RST;
  logic [7:0]  cfg_end = END_CODE_RST;
  logic [15:0] cfg_crc = CRC_INITIAL_RST;
  phase_e      ph = PH_IDLE;
  logic [7:0]  fstore [BufBytes];
  int          fill = 0;
  int          exp_len = 0;
  logic [7:0]  replay [$];
  res_t        pending_results [$];
  res_t        typed_checks [$];
  int          errors = 0;
  int          n_items = 0;
  int          n_results = 0;
  int          n_good = 0, n_crc = 0, n_len = 0, n_frm = 0;
  int          sink_wait = 0;

  initial begin
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    res_ch.ready = 1'b0;
    apb.psel = 1'b0;
    apb.penable = 1'b0;
    apb.pwrite = 1'b0;
    apb.paddr = '0;
    apb.pwdata = '0;
  end

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    c ^= {b, 8'h00};
    for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    return c;
  endfunction

  function automatic res_t mk(logic [1:0] st, logic [7:0] d, logic v, int len, logic last);
    res_t r;
    r.status = st; r.data_byte = d; r.data_valid = v;
    r.frame_length = 5'(len); r.last_of_run = last;
    return r;
  endfunction

  task automatic parse_one(input logic [7:0] b);
    int n;
    logic [15:0] c;
    logic [7:0] tail [$];
    case (ph)
      PH_IDLE: if (b == cfg_start) begin
        fstore[0] = b; fill = 1; ph = PH_LENGTH;
      end
      PH_LENGTH: if (int'(b) > int'(MaxLen)) begin
        pending_results.push_back(mk(STATUS_LEN, 0, 0, 0, 1));
        ph = PH_IDLE; fill = 0;
      end else begin
        exp_len = b; fstore[1] = b; fill = 2; ph = PH_BODY;
      end
      default: begin
        fstore[fill] = b; fill++;
        if (fill >= exp_len + 5) begin
          n = fill; ph = PH_IDLE; fill = 0;
          if (b == cfg_end) begin
            c = cfg_crc;
            for (int i = 0; i < exp_len; i++) c = crc_step(c, fstore[2 + i]);
            if (c == {fstore[exp_len + 3], fstore[exp_len + 2]}) begin
              if (exp_len == 0) pending_results.push_back(mk(STATUS_GOOD, 0, 0, 0, 1));
              for (int i = 0; i < exp_len; i++)
                pending_results.push_back(mk(STATUS_GOOD, fstore[2 + i], 1, exp_len,
                                             i + 1 == exp_len));
            end else pending_results.push_back(mk(STATUS_CRC, 0, 0, exp_len, 1));
          end else begin
            pending_results.push_back(mk(STATUS_FRAME, 0, 0, exp_len, 1));
            for (int j = 1; j + 1 < n; j++) if (fstore[j] == cfg_start) begin
              for (int i = j; i < n; i++) tail.push_back(fstore[i]);
              while (replay.size() > 0 && tail.size() < BufBytes)
                tail.push_back(replay.pop_front());
              replay = tail;
              break;
            end
          end
        end
      end
    endcase
  endtask

  task automatic predict_frame_results(input logic [7:0] b);
    replay.delete();
    parse_one(b);
    while (replay.size() > 0) parse_one(replay.pop_front());
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    apb.psel <= 1'b1; apb.penable <= 1'b0; apb.pwrite <= 1'b1;
    apb.paddr <= {idx, 2'b00}; apb.pwdata <= val;
    @(posedge clk_i);
    apb.penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    apb.psel <= 1'b0; apb.penable <= 1'b0; apb.pwrite <= 1'b0;
    case (idx)
      REG_START_CODE: cfg_start = val[7:0];
      REG_END_CODE:   cfg_end = val[7:0];
      default:        cfg_crc = val[15:0];
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    rx_ch.valid <= 1'b1; rx_ch.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_ch.ready) @(posedge clk_i);
    predict_frame_results(b);
    n_items++;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    rx_ch.valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] pl [$], input bit bad_crc, input bit bad_end);
    logic [15:0] c;
    c = cfg_crc;
    foreach (pl[i]) c = crc_step(c, pl[i]);
    if (bad_crc) c ^= 16'(1 << $urandom_range(0, 15));
    send_byte(cfg_start);
    send_byte(8'(pl.size()));
    foreach (pl[i]) send_byte(pl[i]);
    send_byte(c[7:0]);
    send_byte(c[15:8]);
    send_byte(bad_end ? cfg_end ^ 8'(1 << $urandom_range(0, 7)) : cfg_end);
  endtask

  task automatic rand_frame(input int maxlen);
    logic [7:0] pl [$];
    int len, kind;
    len = ($urandom_range(0, 9) == 0) ? maxlen : $urandom_range(0, 6);
    for (int i = 0; i < len; i++)
      pl.push_back(($urandom_range(0, 7) == 0) ? cfg_start : 8'($urandom));
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      send_byte(cfg_start);
      send_byte(8'($urandom_range(int'(MaxLen) + 1, 255)));
    end else if (kind == 1) send_byte(8'($urandom));
    else send_frame(pl, kind == 2, kind == 3);
  endtask

  always @(posedge clk_i) begin
    res_t got, want;
    if (res_ch.valid && res_ch.ready) begin
      got = mk(res_ch.status, res_ch.data_byte, res_ch.data_valid,
               res_ch.frame_length, res_ch.last_of_run);
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result expected none actual %p", $realtime, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (typed_checks.size() > 0 && want == typed_checks[0]) void'(typed_checks.pop_front());
        case (want.status)
          STATUS_GOOD: if (want.last_of_run) n_good++;
          STATUS_CRC: n_crc++;
          STATUS_LEN: n_len++;
          default: n_frm++;
        endcase
        if (got.status !== want.status || got.data_byte !== want.data_byte ||
            got.data_valid !== want.data_valid || got.frame_length !== want.frame_length ||
            got.last_of_run !== want.last_of_run) begin
          $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
          errors++;
        end
      end
      sink_wait = $urandom_range(0, 7);
    end else if (sink_wait > 0) begin
      sink_wait--;
    end
    res_ch.ready <= (sink_wait == 0);
  end

  initial begin
    stim_row_t dir_rows [$];
    logic [7:0] pl [$];
    stim_row_t r;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // empty frame with reset config (CRC of nothing is 0xFFFF), then length, CRC and framing errors
    dir_rows = '{
      '{8'h00, 0, '0}, '{8'hFF, 0, '0},
      '{8'h7E, 0, '0}, '{8'h00, 0, '0}, '{8'hFF, 0, '0}, '{8'hFF, 0, '0},
      '{8'h7F, 1, '{STATUS_GOOD, 8'h00, 1'b0, 5'd0, 1'b1}},
      '{8'h7E, 0, '0}, '{8'hFF, 1, '{STATUS_LEN, 8'h00, 1'b0, 5'd0, 1'b1}},
      '{8'h7E, 0, '0}, '{8'h1C, 1, '{STATUS_LEN, 8'h00, 1'b0, 5'd0, 1'b1}},
      '{8'h7E, 0, '0}, '{8'h00, 0, '0}, '{8'h00, 0, '0}, '{8'h00, 0, '0},
      '{8'h7F, 1, '{STATUS_CRC, 8'h00, 1'b0, 5'd0, 1'b1}},
      '{8'h7E, 0, '0}, '{8'h00, 0, '0}, '{8'h7E, 0, '0}, '{8'h01, 0, '0},
      '{8'h55, 1, '{STATUS_FRAME, 8'h00, 1'b0, 5'd0, 1'b1}},
      '{8'hAA, 0, '0}, '{8'h00, 0, '0}, '{8'h00, 0, '0}, '{8'h7F, 0, '0}
    };
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.has_want) typed_checks.push_back(r.want);
      send_byte(r.rx);
    end
    drain();
    if (typed_checks.size() != 0) begin
      $display("%0t: directed check missed expected %p actual none", $realtime,
               typed_checks[0]);
      errors++;
    end
    // longest payload, early end codes as data
    for (int i = 0; i < MaxLen; i++) pl.push_back(i % 2 ? cfg_end : 8'(i * 9));
    send_frame(pl, 0, 0);
    drain();
    apb_write(REG_START_CODE, 32'h00);
    apb_write(REG_END_CODE, 32'hFF);
    apb_write(REG_CRC_INITIAL, 32'h0000);
    pl = '{8'h00, 8'hFF};
    send_frame(pl, 0, 0);
    for (int i = 0; i < 3; i++) rand_frame(MaxLen);
    drain();
    apb_write(REG_START_CODE, 32'hFF);
    apb_write(REG_END_CODE, 32'h00);
    apb_write(REG_CRC_INITIAL, 32'hFFFF);
    for (int i = 0; i < 3; i++) rand_frame(MaxLen);
    drain();
    apb_write(REG_START_CODE, $urandom_range(0, 255));
    apb_write(REG_END_CODE, $urandom_range(0, 255));
    apb_write(REG_CRC_INITIAL, $urandom_range(0, 65535));
    for (int i = 0; i < 3; i++) rand_frame(MaxLen);
    drain();
    $display("Sent %0d bytes, checked %0d results: %0d good frames, %0d crc, %0d length,",
             n_items, n_results, n_good, n_crc, n_len);
    $display("%0d framing errors over four register settings.", n_frm);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
